// ===== rtl/core/mwm3_pkg.sv =====
// Shared types, constants and helpers for the masked 3D window mean block.
package mwm3_pkg;

    localparam int unsigned DEF_MAX_DIM_X = 32;
    localparam int unsigned DEF_MAX_DIM_Y = 32;
    localparam int unsigned DEF_MAX_DIM_Z = 32;

    localparam int unsigned SIZE_W  = 6;
    localparam int unsigned COORD_W = 5;
    localparam int unsigned HALF_W  = 5;
    localparam int unsigned VOXEL_W = 8;
    localparam int unsigned PLANE_W = 2 * SIZE_W;
    // Sizes are capped at 63, so every linear index and count fits in 18 bits.
    localparam int unsigned PTR_W   = 3 * SIZE_W;
    localparam int unsigned CNT_W   = 3 * SIZE_W;
    localparam int unsigned SUM_W   = CNT_W + 7;
    localparam int unsigned REM_W   = SUM_W + 8;
    localparam int unsigned QUOT_W  = 15;
    localparam int unsigned STEP_W  = $clog2(QUOT_W);
    localparam int unsigned OCNT_W  = 16;

    localparam int unsigned APB_AW = 4;
    localparam int unsigned APB_DW = 32;

    localparam logic [VOXEL_W-1:0] SKIP_CODE   = 8'd255;
    localparam logic [VOXEL_W-1:0] CLAMP_LEVEL = 8'd100;
    localparam logic [SIZE_W-1:0]  SIZE_RESET  = 6'd32;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef enum logic [1:0] {
        REG_SIZE_X = 2'd0,
        REG_SIZE_Y = 2'd1,
        REG_SIZE_Z = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [SIZE_W-1:0] size_x;
        logic [SIZE_W-1:0] size_y;
        logic [SIZE_W-1:0] size_z;
    } t_cfg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_BASE,
        ST_WRITE,
        ST_WALK,
        ST_DRAIN,
        ST_DINIT,
        ST_DIV,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic accept;
        logic mul1;
        logic mul2;
        logic base;
        logic write;
        logic walk;
        logic dinit;
        logic div_step;
    } t_dp_cmd;

    typedef struct packed {
        logic q_empty;
        logic walk_last;
        logic cnt_zero;
        logic div_last;
    } t_dp_stat;

    // Register value limited to the built extent of its axis.
    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] r,
                                                   input int unsigned m);
        logic [SIZE_W-1:0] res;
        res = r;
        if (m < (1 << SIZE_W) && 32'(r) > m) begin
            res = SIZE_W'(m);
        end
        return res;
    endfunction

endpackage

// ===== rtl/core/masked_window_mean_3d.sv =====
// Top level of the masked 3D window mean block.
// A request is taken when start is high and busy is low. A load (action 0)
// steps through MUL1, MUL2, BASE and WRITE with busy high and gives no result;
// loads outside the volume are dropped. A query (action 1) reads the clipped
// window from the voxel store one voxel per cycle through its single port. It
// passes through MUL1, MUL2 and BASE for address set-up, WALK for the reads,
// DRAIN and DINIT to drain the read and load the divider, DIV for the
// bit-per-cycle divider and DONE for the result. A clipped window that is empty
// goes from MUL1 straight to DONE, and one whose voxels are all skipped goes from DINIT to DONE, as
// the divider is bypassed. The result appears on the o_ ports for exactly one
// cycle with o_done high and cannot be held off; the receiver must take it
// then. The extent registers sit at byte addresses 0, 4 and 8; the user must
// write them only while busy is low, as the block itself does not enforce this.
module masked_window_mean_3d #(
    parameter int unsigned MAX_DIM_X = mwm3_pkg::DEF_MAX_DIM_X,
    parameter int unsigned MAX_DIM_Y = mwm3_pkg::DEF_MAX_DIM_Y,
    parameter int unsigned MAX_DIM_Z = mwm3_pkg::DEF_MAX_DIM_Z
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mwm3_pkg::APB_AW-1:0]   paddr,
    input  logic [mwm3_pkg::APB_DW-1:0]   pwdata,
    output logic [mwm3_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_action,
    input  logic [mwm3_pkg::VOXEL_W-1:0]  i_voxel_value,
    input  logic [mwm3_pkg::COORD_W-1:0]  i_pos_z,
    input  logic [mwm3_pkg::COORD_W-1:0]  i_pos_y,
    input  logic [mwm3_pkg::COORD_W-1:0]  i_pos_x,
    input  logic [mwm3_pkg::HALF_W-1:0]   i_half_window,
    output logic                          o_done,
    output logic [mwm3_pkg::QUOT_W-1:0]   o_mean_scaled,
    output logic [mwm3_pkg::OCNT_W-1:0]   o_voxel_count,
    output logic                          o_empty_window
);
    import mwm3_pkg::*;

    t_cfg     cfg;
    t_dp_cmd  cmd;
    t_dp_stat stat;

    mwm3_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    mwm3_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_action (i_action),
        .i_stat   (stat),
        .o_cmd    (cmd),
        .busy     (busy),
        .o_done   (o_done)
    );

    mwm3_dp #(
        .MAX_DIM_X (MAX_DIM_X),
        .MAX_DIM_Y (MAX_DIM_Y),
        .MAX_DIM_Z (MAX_DIM_Z)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_action       (i_action),
        .i_voxel_value  (i_voxel_value),
        .i_pos_z        (i_pos_z),
        .i_pos_y        (i_pos_y),
        .i_pos_x        (i_pos_x),
        .i_half_window  (i_half_window),
        .o_mean_scaled  (o_mean_scaled),
        .o_voxel_count  (o_voxel_count),
        .o_empty_window (o_empty_window)
    );

endmodule

// ===== rtl/core/mwm3_cfg.sv =====
// APB register file holding the three volume extents.
module mwm3_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mwm3_pkg::APB_AW-1:0]   paddr,
    input  logic [mwm3_pkg::APB_DW-1:0]   pwdata,
    output logic [mwm3_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    output mwm3_pkg::t_cfg                o_cfg
);
    import mwm3_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    t_reg_idx   reg_idx;

    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = t_reg_idx'(paddr[3:2]);
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.size_x <= SIZE_RESET;
            r_cfg.size_y <= SIZE_RESET;
            r_cfg.size_z <= SIZE_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_SIZE_X: r_cfg.size_x <= pwdata[SIZE_W-1:0];
                REG_SIZE_Y: r_cfg.size_y <= pwdata[SIZE_W-1:0];
                REG_SIZE_Z: r_cfg.size_z <= pwdata[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_SIZE_X: prdata = APB_DW'(r_cfg.size_x);
            REG_SIZE_Y: prdata = APB_DW'(r_cfg.size_y);
            REG_SIZE_Z: prdata = APB_DW'(r_cfg.size_z);
            default:    prdata = '0;
        endcase
    end

endmodule

// ===== rtl/core/mwm3_ctrl.sv =====
// Sequencer for load and query requests.
module mwm3_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  logic                i_action,
    input  mwm3_pkg::t_dp_stat  i_stat,
    output mwm3_pkg::t_dp_cmd   o_cmd,
    output logic                busy,
    output logic                o_done
);
    import mwm3_pkg::*;

    t_state r_state, n_state;
    logic   r_is_query, n_is_query;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_is_query <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_is_query <= n_is_query;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_is_query = r_is_query;
        o_cmd      = '0;
        busy       = 1'b1;
        o_done     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    o_cmd.accept = 1'b1;
                    n_is_query   = (i_action == ACT_QUERY);
                    n_state      = ST_MUL1;
                end
            end
            ST_MUL1: begin
                o_cmd.mul1 = 1'b1;
                // empty clipped window: nothing to read
                if (r_is_query && i_stat.q_empty) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_MUL2;
                end
            end
            ST_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state    = ST_BASE;
            end
            ST_BASE: begin
                o_cmd.base = 1'b1;
                n_state    = r_is_query ? ST_WALK : ST_WRITE;
            end
            ST_WRITE: begin
                o_cmd.write = 1'b1;
                n_state     = ST_IDLE;
            end
            ST_WALK: begin
                o_cmd.walk = 1'b1;
                if (i_stat.walk_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_DINIT;
            end
            ST_DINIT: begin
                o_cmd.dinit = 1'b1;
                n_state     = i_stat.cnt_zero ? ST_DONE : ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                o_done  = 1'b1;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/mwm3_dp.sv =====
// Datapath: window clipping, address walk, voxel store, accumulation and divider.
module mwm3_dp #(
    parameter int unsigned MAX_DIM_X = mwm3_pkg::DEF_MAX_DIM_X,
    parameter int unsigned MAX_DIM_Y = mwm3_pkg::DEF_MAX_DIM_Y,
    parameter int unsigned MAX_DIM_Z = mwm3_pkg::DEF_MAX_DIM_Z
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  mwm3_pkg::t_cfg                 i_cfg,
    input  mwm3_pkg::t_dp_cmd              i_cmd,
    output mwm3_pkg::t_dp_stat             o_stat,
    input  logic                           i_action,
    input  logic [mwm3_pkg::VOXEL_W-1:0]   i_voxel_value,
    input  logic [mwm3_pkg::COORD_W-1:0]   i_pos_z,
    input  logic [mwm3_pkg::COORD_W-1:0]   i_pos_y,
    input  logic [mwm3_pkg::COORD_W-1:0]   i_pos_x,
    input  logic [mwm3_pkg::HALF_W-1:0]    i_half_window,
    output logic [mwm3_pkg::QUOT_W-1:0]    o_mean_scaled,
    output logic [mwm3_pkg::OCNT_W-1:0]    o_voxel_count,
    output logic                           o_empty_window
);
    import mwm3_pkg::*;

    localparam int unsigned DEPTH   = MAX_DIM_X * MAX_DIM_Y * MAX_DIM_Z;
    localparam int unsigned ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [VOXEL_W-1:0] r_mem [DEPTH];

    logic [SIZE_W-1:0]  sx, sy, sz;
    logic [SIZE_W-1:0]  lo_x, lo_y, lo_z, hi_x, hi_y, hi_z;
    logic               clip_empty, load_ok, is_query;

    logic [SIZE_W-1:0]  r_lo_y, r_lo_z, r_hi_x, r_hi_y, r_hi_z, r_lo_x;
    logic [SIZE_W-1:0]  r_x, r_y, r_z;
    logic               r_empty, r_load_ok;
    logic [VOXEL_W-1:0] r_val;
    logic [PLANE_W-1:0] r_plane, r_yoff;
    logic [PTR_W-1:0]   r_zoff, r_plane_ptr, r_row_ptr;
    logic [ADDR_W-1:0]  mem_addr;

    logic               r_rd_vld;
    logic [VOXEL_W-1:0] r_rd_data;
    logic [VOXEL_W-1:0] clamped;
    logic [CNT_W-1:0]   r_count;
    logic [SUM_W-1:0]   r_sum;

    logic [REM_W-1:0]   r_rem, r_div;
    logic [QUOT_W-1:0]  r_quot;
    logic [STEP_W-1:0]  r_step;

    assign sx = eff_size(i_cfg.size_x, MAX_DIM_X);
    assign sy = eff_size(i_cfg.size_y, MAX_DIM_Y);
    assign sz = eff_size(i_cfg.size_z, MAX_DIM_Z);

    assign is_query = (i_action == ACT_QUERY);

    // Lower corner: clipped window start for a query, the voxel itself for a load.
    function automatic logic [SIZE_W-1:0] clip_lo(input logic [COORD_W-1:0] p,
                                                  input logic [HALF_W-1:0] h,
                                                  input logic q);
        logic [SIZE_W-1:0] res;
        res = SIZE_W'(p);
        if (q) begin
            res = (p > h) ? SIZE_W'(p - h) : '0;
        end
        return res;
    endfunction

    function automatic logic [SIZE_W-1:0] clip_hi(input logic [COORD_W-1:0] p,
                                                  input logic [HALF_W-1:0] h,
                                                  input logic [SIZE_W-1:0] s);
        logic [SIZE_W-1:0] top;
        logic [SIZE_W-1:0] lim;
        top = SIZE_W'(p) + SIZE_W'(h);
        lim = s - 1'b1;
        return (top < lim) ? top : lim;
    endfunction

    always_comb begin
        lo_x = clip_lo(i_pos_x, i_half_window, is_query);
        lo_y = clip_lo(i_pos_y, i_half_window, is_query);
        lo_z = clip_lo(i_pos_z, i_half_window, is_query);
        hi_x = clip_hi(i_pos_x, i_half_window, sx);
        hi_y = clip_hi(i_pos_y, i_half_window, sy);
        hi_z = clip_hi(i_pos_z, i_half_window, sz);
        clip_empty = (sx == '0) || (sy == '0) || (sz == '0) ||
                     (lo_x > hi_x) || (lo_y > hi_y) || (lo_z > hi_z);
        load_ok = (SIZE_W'(i_pos_x) < sx) && (SIZE_W'(i_pos_y) < sy) &&
                  (SIZE_W'(i_pos_z) < sz);
    end

    assign mem_addr = ADDR_W'(r_row_ptr + PTR_W'(r_x));

    // Request capture, address set-up and the x/y/z walk.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_lo_x    <= lo_x;
            r_lo_y    <= lo_y;
            r_lo_z    <= lo_z;
            r_hi_x    <= hi_x;
            r_hi_y    <= hi_y;
            r_hi_z    <= hi_z;
            r_x       <= lo_x;
            r_y       <= lo_y;
            r_z       <= lo_z;
            r_empty   <= clip_empty;
            r_load_ok <= load_ok;
            r_val     <= i_voxel_value;
        end
        if (i_cmd.mul1) begin
            r_plane <= PLANE_W'(sx) * PLANE_W'(sy);
            r_yoff  <= PLANE_W'(r_lo_y) * PLANE_W'(sx);
        end
        if (i_cmd.mul2) begin
            r_zoff <= PTR_W'(r_lo_z) * PTR_W'(r_plane);
        end
        if (i_cmd.base) begin
            r_plane_ptr <= r_zoff;
            r_row_ptr   <= r_zoff + PTR_W'(r_yoff);
        end
        if (i_cmd.walk) begin
            if (r_x == r_hi_x) begin
                r_x <= r_lo_x;
                if (r_y == r_hi_y) begin
                    r_y         <= r_lo_y;
                    r_z         <= r_z + 1'b1;
                    r_plane_ptr <= r_plane_ptr + PTR_W'(r_plane);
                    r_row_ptr   <= r_plane_ptr + PTR_W'(r_plane) + PTR_W'(r_yoff);
                end else begin
                    r_y       <= r_y + 1'b1;
                    r_row_ptr <= r_row_ptr + PTR_W'(sx);
                end
            end else begin
                r_x <= r_x + 1'b1;
            end
        end
    end

    // Voxel store: one write or one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.write && r_load_ok) begin
            r_mem[mem_addr] <= r_val;
        end
        if (i_cmd.walk) begin
            r_rd_data <= r_mem[mem_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.walk;
        end
    end

    assign clamped = (r_rd_data > CLAMP_LEVEL) ? CLAMP_LEVEL : r_rd_data;

    // Accumulation and restoring division of sum*256 by count.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_count <= '0;
            r_sum   <= '0;
            r_quot  <= '0;
        end else if (r_rd_vld && r_rd_data != SKIP_CODE) begin
            r_count <= r_count + 1'b1;
            r_sum   <= r_sum + SUM_W'(clamped);
        end
        if (i_cmd.dinit) begin
            r_rem  <= {r_sum, 8'b0};
            r_div  <= REM_W'(r_count) << (QUOT_W - 1);
            r_step <= STEP_W'(QUOT_W - 1);
        end
        if (i_cmd.div_step) begin
            if (r_rem >= r_div) begin
                r_rem          <= r_rem - r_div;
                r_quot[r_step] <= 1'b1;
            end
            r_div  <= r_div >> 1;
            r_step <= r_step - 1'b1;
        end
    end

    assign o_stat.q_empty   = r_empty;
    assign o_stat.walk_last = (r_x == r_hi_x) && (r_y == r_hi_y) && (r_z == r_hi_z);
    assign o_stat.cnt_zero  = (r_count == '0);
    assign o_stat.div_last  = (r_step == '0);

    assign o_mean_scaled  = r_quot;
    assign o_voxel_count  = OCNT_W'(r_count);
    assign o_empty_window = (r_count == '0);

endmodule
